// File: rtl/core/rke_pkg.sv
// ----------------------------------------------------------------------------
// rke_pkg: shared types and constants for the rotary knob event unit
// Event codes, configuration layout, queue entry format and ring helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rke_pkg;

	localparam int RING_DEPTH  = 16;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int EV_SLOTS    = 4;   // encoder, edge, press, long
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int IN_W       = 40;
	localparam int OUT_W      = 104;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_CW,
		EV_CCW,
		EV_DOWN,
		EV_PRESS,
		EV_DOUBLE,
		EV_LONG
	} ev_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CPD,
		CFG_INVERT,
		CFG_DEBOUNCE,
		CFG_DWIN,
		CFG_LONG
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]  cpd;
		logic        invert;
		logic [7:0]  debounce_ms;
		logic [15:0] double_window_ms;
		logic [15:0] long_press_ms;
	} cfg_t;

	// one classified sample, front to back
	typedef struct packed {
		logic [2:0]                  ev_cnt;
		ev_code_t [EV_SLOTS-1:0]     ev;
		logic                        pop;
		logic                        mark;
		logic [31:0]                 now_ms;
		logic [31:0]                 hold_ms;
		logic [31:0]                 position;
	} qent_t;

	// quadrature step, indexed by {prev_ab, ab}
	localparam logic signed [1:0] QUAD_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	// ring index plus a small offset; offset keeps the sum below two laps
	function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] a,
			input logic [2:0] n);
		logic [RING_AW+2:0] s;
		s = (RING_AW+3)'(a) + (RING_AW+3)'(n);
		if (s >= (RING_AW+3)'(RING_DEPTH)) begin
			s = s - (RING_AW+3)'(RING_DEPTH);
		end
		return s[RING_AW-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/rke_front.sv
// ----------------------------------------------------------------------------
// rke_front: sample classifier
// Decodes the quadrature lines and classifies the button per sample, then
// pushes the resulting events and snapshot values into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rke_front import rke_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [IN_W-1:0] in_data,
	input  cfg_t            cfg,
	input  logic            q_full,
	output logic            q_push,
	output qent_t           q_ent
);

	logic        line_a, line_b, button_level, button_poll, pop_event, mark_activity;
	logic [31:0] now_ms;

	assign line_a        = in_data[0];
	assign line_b        = in_data[1];
	assign button_level  = in_data[2];
	assign button_poll   = in_data[3];
	assign now_ms        = in_data[35:4];
	assign pop_event     = in_data[36];
	assign mark_activity = in_data[37];

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// encoder state
	logic [1:0]        prev_ab_q;
	logic signed [3:0] acc_q;
	logic [31:0]       pos_q;

	// button state
	logic        pressed_q, long_q, await_q;
	logic [31:0] press_t_q, edge_t_q, rel_t_q;

	logic [1:0]        ab_cur;
	logic signed [1:0] step, step_dir;
	logic signed [4:0] acc_sum, lim, nlim;
	logic signed [3:0] acc_n;
	logic [31:0]       pos_n;
	ev_code_t          ev_enc;

	assign ab_cur   = {line_a, line_b};
	assign step     = QUAD_TABLE[{prev_ab_q, ab_cur}];
	assign step_dir = cfg.invert ? -step : step;
	assign acc_sum  = {acc_q[3], acc_q} + {{3{step_dir[1]}}, step_dir};
	assign lim      = $signed({2'b00, cfg.cpd});
	assign nlim     = -lim;

	always_comb begin
		acc_n  = acc_q;
		pos_n  = pos_q;
		ev_enc = EV_NONE;
		if (step_dir != 2'sd0) begin
			pos_n = pos_q + {{30{step_dir[1]}}, step_dir};
			if (acc_sum >= lim) begin
				acc_n  = 4'sd0;
				ev_enc = EV_CW;
			end else if (acc_sum <= nlim) begin
				acc_n  = 4'sd0;
				ev_enc = EV_CCW;
			end else begin
				acc_n = acc_sum[3:0];
			end
		end
	end

	logic        pressed_n, long_n, await_n, down;
	logic [31:0] press_t_n, edge_t_n, rel_t_n, hold_n;
	ev_code_t    ev_edge, ev_press, ev_long;

	assign down = !button_level;

	always_comb begin
		pressed_n = pressed_q;
		long_n    = long_q;
		await_n   = await_q;
		press_t_n = press_t_q;
		edge_t_n  = edge_t_q;
		rel_t_n   = rel_t_q;
		ev_edge   = EV_NONE;
		ev_press  = EV_NONE;
		ev_long   = EV_NONE;
		if (button_poll) begin
			if (down != pressed_q && (now_ms - edge_t_q) > {24'd0, cfg.debounce_ms}) begin
				edge_t_n  = now_ms;
				pressed_n = down;
				if (down) begin
					press_t_n = now_ms;
					long_n    = 1'b0;
					ev_edge   = EV_DOWN;
				end else if (!long_q) begin
					if (await_q && (now_ms - rel_t_q) <= {16'd0, cfg.double_window_ms}) begin
						await_n = 1'b0;
						ev_edge = EV_DOUBLE;
					end else begin
						await_n = 1'b1;
						rel_t_n = now_ms;
					end
				end else begin
					await_n = 1'b0;
				end
			end
			// release window closed: single press
			if (await_n && (now_ms - rel_t_n) > {16'd0, cfg.double_window_ms}) begin
				await_n  = 1'b0;
				ev_press = EV_PRESS;
			end
			if (pressed_n && !long_n &&
					(now_ms - press_t_n) >= {16'd0, cfg.long_press_ms}) begin
				long_n  = 1'b1;
				await_n = 1'b0;
				ev_long = EV_LONG;
			end
		end
		hold_n = (pressed_n && !long_n) ? (now_ms - press_t_n) : 32'd0;
	end

	// pack events in order, oldest slot first
	ev_code_t [EV_SLOTS-1:0] ev_raw, ev_c;
	logic [2:0]              ev_cnt;

	assign ev_raw = {ev_long, ev_press, ev_edge, ev_enc};

	always_comb begin
		ev_cnt = 3'd0;
		ev_c   = {EV_SLOTS{EV_NONE}};
		for (int i = 0; i < EV_SLOTS; i++) begin
			if (ev_raw[i] != EV_NONE) begin
				ev_c[ev_cnt[1:0]] = ev_raw[i];
				ev_cnt            = ev_cnt + 3'd1;
			end
		end
	end

	always_comb begin
		q_ent.ev_cnt   = ev_cnt;
		q_ent.ev       = ev_c;
		q_ent.pop      = pop_event;
		q_ent.mark     = mark_activity;
		q_ent.now_ms   = now_ms;
		q_ent.hold_ms  = hold_n;
		q_ent.position = pos_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q <= 2'b11;
			acc_q     <= 4'sd0;
			pos_q     <= 32'd0;
			pressed_q <= 1'b0;
			long_q    <= 1'b0;
			await_q   <= 1'b0;
			press_t_q <= 32'd0;
			edge_t_q  <= 32'd0;
			rel_t_q   <= 32'd0;
		end else if (q_push) begin
			prev_ab_q <= ab_cur;
			acc_q     <= acc_n;
			pos_q     <= pos_n;
			pressed_q <= pressed_n;
			long_q    <= long_n;
			await_q   <= await_n;
			press_t_q <= press_t_n;
			edge_t_q  <= edge_t_n;
			rel_t_q   <= rel_t_n;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rke_queue.sv
// ----------------------------------------------------------------------------
// rke_queue: short FIFO between classifier and event ring
// Holds classified samples so either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module rke_queue import rke_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_ent,
	output logic  full,
	output logic  valid,
	input  logic  pop,
	output qent_t head_ent
);

	qent_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full     = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign valid    = (cnt_q != '0);
	assign head_ent = slot_q[rd_q];

	function automatic logic [QUEUE_AW-1:0] qnext(input logic [QUEUE_AW-1:0] p);
		return (p == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : p + QUEUE_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= qnext(wr_q);
			end
			if (pop) begin
				rd_q <= qnext(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rke_back.sv
// ----------------------------------------------------------------------------
// rke_back: event ring and result register
// Enqueues classified events, serves pops, tracks activity, forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module rke_back import rke_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  qent_t            q_ent,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] out_data
);

	ev_code_t           ring_q [RING_DEPTH];
	logic [RING_AW-1:0] head_q, tail_q;
	logic [31:0]        act_q;
	logic               out_v_q;
	logic [OUT_W-1:0]   out_d_q;

	logic                fire;
	logic [RING_AW:0]    cnt_wide;
	logic [RING_AW-1:0]  cnt, free;
	logic [RING_AW+2:0]  free_x, evc_x;
	logic [2:0]          nacc;
	logic [RING_AW:0]    cnt_after;
	logic                pop_ok;
	ev_code_t            pop_code;
	logic [31:0]         act_n, idle_ms;
	logic [RING_AW-1:0]  head_n, tail_n;

	assign fire  = q_valid && (!out_v_q || out_ready);
	assign q_pop = fire;

	// occupancy of the ring before this sample
	assign cnt_wide = (RING_AW+1)'(head_q) - (RING_AW+1)'(tail_q)
		+ ((head_q < tail_q) ? (RING_AW+1)'(RING_DEPTH) : '0);
	assign cnt  = cnt_wide[RING_AW-1:0];
	assign free = RING_AW'(RING_DEPTH-1) - cnt;

	// newest events are dropped once the ring is full
	assign free_x = (RING_AW+3)'(free);
	assign evc_x  = (RING_AW+3)'(q_ent.ev_cnt);
	assign nacc   = (evc_x > free_x) ? free_x[2:0] : q_ent.ev_cnt;
	assign head_n = ring_add(head_q, nacc);

	assign cnt_after = (RING_AW+1)'(cnt) + (RING_AW+1)'(nacc);
	assign pop_ok    = q_ent.pop && (cnt_after != '0);
	// an empty ring pops the first event written in this same step
	assign pop_code  = !pop_ok ? EV_NONE : ((cnt == '0) ? q_ent.ev[0] : ring_q[tail_q]);
	assign tail_n    = pop_ok ? ring_add(tail_q, 3'd1) : tail_q;
	assign act_n     = (pop_ok || q_ent.mark) ? q_ent.now_ms : act_q;
	assign idle_ms   = q_ent.now_ms - act_n;

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < EV_SLOTS; i++) begin
				if (3'(i) < nacc) begin
					ring_q[ring_add(head_q, 3'(i))] <= q_ent.ev[i];
				end
			end
			out_d_q <= {4'd0, idle_ms, q_ent.position, q_ent.hold_ms, pop_code, pop_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			act_q   <= 32'd0;
			out_v_q <= 1'b0;
		end else begin
			if (fire) begin
				head_q <= head_n;
				tail_q <= tail_n;
				act_q  <= act_n;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

endmodule

`default_nettype wire

// File: rtl/core/rotary_knob_event_unit_core.sv
// ----------------------------------------------------------------------------
// rotary_knob_event_unit_core: quadrature knob and button event unit
// Decodes encoder lines, classifies button gestures, queues knob events.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one pin sample per transfer (levels, poll flag,
//   timestamp, pop and activity requests). m_* channel returns exactly one
//   result per sample: popped event, hold time, raw position, idle time.
//   cfg_* channel writes the five setup registers; it is always ready. The user
//   must write it only while the unit is idle; the block does not enforce this.
// Timing:
//   An accepted sample goes through the classifier into a two-entry queue,
//   then through the ring stage into the output register. One sample per
//   cycle is sustained while m_tready stays high.
// Reset:
//   Encoder sees both lines high, ring empty, button released, all
//   timestamps zero, registers at their defaults.
// Back pressure:
//   A stalled m_tready holds the output register; the two-entry queue then
//   fills and s_tready drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_knob_event_unit_core import rke_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample in
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [0] line_a, [1] line_b, [2] button_level, [3] button_poll,
	// [35:4] now_ms, [36] pop_event, [37] mark_activity, [39:38] zero
	input  logic [IN_W-1:0]       s_tdata,
	// result out
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] event_valid, [3:1] event_code, [35:4] hold_time_ms,
	// [67:36] raw_position, [99:68] idle_time_ms, [103:100] zero
	output logic [OUT_W-1:0]      m_tdata,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_full, q_push, q_valid, q_pop;
	qent_t push_ent, head_ent;

	assign cfg_ready = 1'b1;

	// register file; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpd              <= 3'd4;
			cfg_q.invert           <= 1'b0;
			cfg_q.debounce_ms      <= 8'd25;
			cfg_q.double_window_ms <= 16'd260;
			cfg_q.long_press_ms    <= 16'd900;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CPD:      cfg_q.cpd              <= cfg_data[2:0];
				CFG_INVERT:   cfg_q.invert           <= cfg_data[0];
				CFG_DEBOUNCE: cfg_q.debounce_ms      <= cfg_data[7:0];
				CFG_DWIN:     cfg_q.double_window_ms <= cfg_data;
				CFG_LONG:     cfg_q.long_press_ms    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: decode and classify
	rke_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ent    (push_ent)
	);

	// decoupling queue
	rke_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (push_ent),
		.full     (q_full),
		.valid    (q_valid),
		.pop      (q_pop),
		.head_ent (head_ent)
	);

	// back: ring, pop, activity, result register
	rke_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ent     (head_ent),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire
